>>> hw/rtl/i8gemm_pkg.sv
package i8gemm_pkg;

    localparam int TILE_MAX = 4;
    localparam int BYTE_W   = 8;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = 4;
    localparam int SEL_W    = 2;
    localparam int ACT_W    = 2;
    localparam int ELEMS    = TILE_MAX * TILE_MAX;

    localparam int S_DATA_W = 136;
    localparam int M_DATA_W = 40;

    typedef enum logic [ACT_W-1:0] {
        ACT_ROW_SUM = 2'd0,
        ACT_COL_SUM = 2'd1,
        ACT_KSLICE  = 2'd2,
        ACT_FINISH  = 2'd3
    } t_action;

    typedef struct packed {
        logic                              vld;
        logic [TILE_MAX-1:0][BYTE_W-1:0]   a;
        logic [TILE_MAX-1:0][BYTE_W-1:0]   b;
    } t_slice;

    typedef struct packed {
        logic             row_we;
        logic             col_we;
        logic [SEL_W-1:0] sel;
        logic [VAL_W-1:0] sum;
        logic [VAL_W-1:0] zp;
    } t_setup;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] acc;
        logic [VAL_W-1:0] prior;
    } t_fin_req;

endpackage

>>> hw/rtl/int8_gemm_tile_zero_point.sv
// One tile of an unsigned 8-bit matrix product with zero-point correction. Setup
// transactions (row sum; column sum with zero point) are never held off. K-slice
// transactions are taken one per cycle: the slice walks a chain of TILE_ROWS*TILE_COLS
// multiply-accumulate cells, one element per cell, one cell per cycle. A finish
// transaction is held off until that chain has drained, and while a previous finish
// still sits in the correction stage; its row_sum*zero_point product is registered in
// that stage, and the final add in the output register. A finish for an element
// outside the live tile is taken and returns nothing.
module int8_gemm_tile_zero_point
    import i8gemm_pkg::*;
#(
    parameter int TILE_ROWS = TILE_MAX,
    parameter int TILE_COLS = TILE_MAX
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data,        // zero_mode
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,    // index, a_row0..3, b_col0..3,
                                                   // sum_value, prior_value
    input  logic [ACT_W-1:0]    i_s_axis_tuser,    // action
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [M_DATA_W-1:0] o_m_axis_tdata     // result_value, element_index
);

    localparam int Cells = TILE_ROWS * TILE_COLS;

    t_action          w_act;
    logic [IDX_W-1:0] w_idx;
    logic [VAL_W-1:0] w_sum;
    logic [VAL_W-1:0] w_prior;
    logic             w_accept;
    logic             w_idx_row_live;
    logic             w_idx_col_live;
    logic             w_elem_live;
    logic             w_chain_busy;
    logic             w_fin_busy;
    logic             w_fin_go;
    logic             r_zero_mode;

    t_slice           w_slice_in;
    t_slice           w_link [Cells+1];
    logic [VAL_W-1:0] w_acc  [ELEMS];
    t_setup           w_setup;
    t_fin_req         w_req;

    assign w_act   = t_action'(i_s_axis_tuser);
    assign w_idx   = i_s_axis_tdata[IDX_W-1:0];
    assign w_sum   = i_s_axis_tdata[IDX_W+8*BYTE_W +: VAL_W];
    assign w_prior = i_s_axis_tdata[IDX_W+8*BYTE_W+VAL_W +: VAL_W];

    assign w_idx_row_live = int'(w_idx) < TILE_ROWS;
    assign w_idx_col_live = int'(w_idx) < TILE_COLS;
    assign w_elem_live    = (int'(w_idx[IDX_W-1:SEL_W]) < TILE_ROWS)
                         && (int'(w_idx[SEL_W-1:0]) < TILE_COLS);

    always_comb begin
        w_chain_busy = 1'b0;
        for (int p = 1; p <= Cells; p++) begin
            w_chain_busy = w_chain_busy | w_link[p].vld;
        end
    end

    assign o_s_axis_tready = (w_act != ACT_FINISH) || (!w_chain_busy && !w_fin_busy);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_fin_go        = w_accept && (w_act == ACT_FINISH) && w_elem_live;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_mode <= 1'b1;
        end else if (i_cfg_valid) begin
            r_zero_mode <= i_cfg_data;
        end
    end

    always_comb begin
        w_slice_in.vld = w_accept && (w_act == ACT_KSLICE);
        for (int i = 0; i < TILE_MAX; i++) begin
            w_slice_in.a[i] = i_s_axis_tdata[IDX_W + i*BYTE_W +: BYTE_W];
            w_slice_in.b[i] = i_s_axis_tdata[IDX_W + (TILE_MAX+i)*BYTE_W +: BYTE_W];
        end
    end

    assign w_link[0] = w_slice_in;

    for (genvar r = 0; r < TILE_MAX; r++) begin : g_row
        for (genvar c = 0; c < TILE_MAX; c++) begin : g_col
            if (r < TILE_ROWS && c < TILE_COLS) begin : g_live
                i8gemm_cell #(
                    .ROW (r),
                    .COL (c)
                ) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_slice (w_link[r*TILE_COLS + c]),
                    .i_clr   (w_fin_go && (w_idx == IDX_W'(r*TILE_MAX + c))),
                    .o_slice (w_link[r*TILE_COLS + c + 1]),
                    .o_acc   (w_acc[r*TILE_MAX + c])
                );
            end else begin : g_pad
                assign w_acc[r*TILE_MAX + c] = '0;
            end
        end
    end

    assign w_setup.row_we = w_accept && (w_act == ACT_ROW_SUM) && w_idx_row_live;
    assign w_setup.col_we = w_accept && (w_act == ACT_COL_SUM) && w_idx_col_live;
    assign w_setup.sel    = w_idx[SEL_W-1:0];
    assign w_setup.sum    = w_sum;
    assign w_setup.zp     = w_prior;

    assign w_req.vld   = w_fin_go;
    assign w_req.idx   = w_idx;
    assign w_req.acc   = w_acc[w_idx];
    assign w_req.prior = w_prior;

    i8gemm_finish u_finish (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_setup         (w_setup),
        .i_req           (w_req),
        .i_zero_mode     (r_zero_mode),
        .o_busy          (w_fin_busy),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

>>> hw/rtl/i8gemm_cell.sv
module i8gemm_cell
    import i8gemm_pkg::*;
#(
    parameter int ROW = 0,
    parameter int COL = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_slice           i_slice,
    input  logic             i_clr,
    output t_slice           o_slice,
    output logic [VAL_W-1:0] o_acc
);

    localparam logic [SEL_W-1:0] RowSel = SEL_W'(ROW);
    localparam logic [SEL_W-1:0] ColSel = SEL_W'(COL);

    logic [VAL_W-1:0]    r_acc;
    logic [VAL_W-1:0]    n_acc;
    logic [2*BYTE_W-1:0] w_prod;
    t_slice              r_slice;

    assign w_prod = i_slice.a[RowSel] * i_slice.b[ColSel];

    always_comb begin
        n_acc = r_acc;
        if (i_clr) begin
            n_acc = '0;
        end else if (i_slice.vld) begin
            n_acc = r_acc + VAL_W'(w_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_slice.vld <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_slice.vld <= i_slice.vld;
        end
        r_slice.a <= i_slice.a;
        r_slice.b <= i_slice.b;
    end

    assign o_slice = r_slice;
    assign o_acc   = r_acc;

endmodule

>>> hw/rtl/i8gemm_finish.sv
module i8gemm_finish
    import i8gemm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_setup              i_setup,
    input  t_fin_req            i_req,
    input  logic                i_zero_mode,
    output logic                o_busy,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [M_DATA_W-1:0] o_m_axis_tdata   // result_value, element_index
);

    logic [VAL_W-1:0] r_row_sum [TILE_MAX];
    logic [VAL_W-1:0] r_col_sum [TILE_MAX];
    logic [VAL_W-1:0] r_zp      [TILE_MAX];

    logic             r_fin_vld;
    logic [VAL_W-1:0] r_prod;
    logic [VAL_W-1:0] r_base;
    logic [IDX_W-1:0] r_fin_idx;

    logic             r_out_vld;
    logic [VAL_W-1:0] r_out_val;
    logic [IDX_W-1:0] r_out_idx;

    logic [SEL_W-1:0] w_row;
    logic [SEL_W-1:0] w_col;
    logic [VAL_W-1:0] w_prod;
    logic [VAL_W-1:0] w_base;
    logic             w_move;

    assign w_row  = i_req.idx[IDX_W-1:SEL_W];
    assign w_col  = i_req.idx[SEL_W-1:0];
    assign w_prod = r_row_sum[w_row] * r_zp[w_col];
    assign w_base = r_col_sum[w_col] + i_req.acc + (i_zero_mode ? '0 : i_req.prior);
    assign w_move = r_fin_vld && (!r_out_vld || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TILE_MAX; i++) begin
                r_row_sum[i] <= '0;
                r_col_sum[i] <= '0;
                r_zp[i]      <= '0;
            end
        end else begin
            if (i_setup.row_we) begin
                r_row_sum[i_setup.sel] <= i_setup.sum;
            end
            if (i_setup.col_we) begin
                r_col_sum[i_setup.sel] <= i_setup.sum;
                r_zp[i_setup.sel]      <= i_setup.zp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_req.vld) begin
                r_fin_vld <= 1'b1;
            end else if (w_move) begin
                r_fin_vld <= 1'b0;
            end
            if (w_move) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (i_req.vld) begin
            r_prod    <= w_prod;
            r_base    <= w_base;
            r_fin_idx <= i_req.idx;
        end
        if (w_move) begin
            r_out_val <= r_prod + r_base;
            r_out_idx <= r_fin_idx;
        end
    end

    assign o_busy          = r_fin_vld;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {(M_DATA_W - VAL_W - IDX_W)'(0), r_out_idx, r_out_val};

endmodule

>>> tb/tb_top.sv
module tb_top;
    import i8gemm_pkg::*;

    localparam int ROWS         = TILE_MAX;
    localparam int COLS         = TILE_MAX;
    localparam int DRAIN_CYCLES = ROWS * COLS + 8;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASES       = 6;
    localparam int PHASE_OPS    = 315;

    typedef struct packed {
        t_action                         act;
        logic [IDX_W-1:0]                idx;
        logic [TILE_MAX-1:0][BYTE_W-1:0] a;
        logic [TILE_MAX-1:0][BYTE_W-1:0] b;
        logic [VAL_W-1:0]                sum;
        logic [VAL_W-1:0]                prior;
    } t_gemm_op;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] elem;
    } t_tile_elem;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_LONG
    } t_rx_mode;

    class tile_elem_checker;
        logic [VAL_W-1:0] acc [ELEMS];
        logic [VAL_W-1:0] row_sum [TILE_MAX];
        logic [VAL_W-1:0] col_sum [TILE_MAX];
        logic [VAL_W-1:0] col_zp [TILE_MAX];
        bit               zero_mode;
        t_tile_elem       due_elems [$];
        int               errors;
        int               rows;
        int               cols;

        function new(int rows_in, int cols_in);
            rows = rows_in;
            cols = cols_in;
            foreach (acc[i]) acc[i] = '0;
            foreach (row_sum[i]) begin
                row_sum[i] = '0;
                col_sum[i] = '0;
                col_zp[i]  = '0;
            end
            zero_mode = 1'b1;
            errors    = 0;
        endfunction

        function void set_zero_mode(bit v);
            zero_mode = v;
        endfunction

        function int waiting();
            return due_elems.size();
        endfunction

        // update the tile state for one accepted transaction
        function void absorb_op(t_gemm_op op);
            int               r;
            int               c;
            logic [VAL_W-1:0] av;
            logic [VAL_W-1:0] bv;
            logic [VAL_W-1:0] prod;
            t_tile_elem       e;
            case (op.act)
                ACT_ROW_SUM: begin
                    if (op.idx < rows) row_sum[op.idx] = op.sum;
                end
                ACT_COL_SUM: begin
                    if (op.idx < cols) begin
                        col_sum[op.idx] = op.sum;
                        col_zp[op.idx]  = op.prior;
                    end
                end
                ACT_KSLICE: begin
                    for (r = 0; r < TILE_MAX; r++) begin
                        av = (r < rows) ? VAL_W'(op.a[r]) : '0;
                        for (c = 0; c < TILE_MAX; c++) begin
                            bv = (c < cols) ? VAL_W'(op.b[c]) : '0;
                            acc[r * TILE_MAX + c] = acc[r * TILE_MAX + c] + av * bv;
                        end
                    end
                end
                default: begin
                    r = op.idx / TILE_MAX;
                    c = op.idx % TILE_MAX;
                    if (r < rows && c < cols) begin
                        prod    = row_sum[r] * col_zp[c];
                        e.value = prod + col_sum[c] + acc[op.idx];
                        if (!zero_mode) e.value = e.value + op.prior;
                        e.elem  = op.idx;
                        acc[op.idx] = '0;
                        due_elems.push_back(e);
                    end
                end
            endcase
        endfunction

        function void check_elem(logic [VAL_W-1:0] value, logic [IDX_W-1:0] elem);
            t_tile_elem e;
            if (due_elems.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: value %h elem %0d", value, elem);
                return;
            end
            e = due_elems.pop_front();
            if (e.value !== value || e.elem !== elem) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected value %h elem %0d, got value %h elem %0d",
                             e.value, e.elem, value, elem);
            end
        endfunction
    endclass

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_valid     = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_data      = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [S_DATA_W-1:0] i_s_axis_tdata  = '0;
    logic [ACT_W-1:0]    i_s_axis_tuser  = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b1;
    logic [M_DATA_W-1:0] o_m_axis_tdata;

    tile_elem_checker chk = new(ROWS, COLS);

    int       cycles     = 0;
    int       ops_issued = 0;
    int       burst_left = 0;
    bit       gaps_on    = 1'b1;
    int       rx_count   = 0;
    t_rx_mode rx_mode    = RX_ALWAYS;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    int8_gemm_tile_zero_point #(
        .TILE_ROWS(ROWS),
        .TILE_COLS(COLS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** int8_gemm_tile_zero_point: FAILED **");
            $finish;
        end
    end

    // result side stalls
    always @(posedge i_clk) begin
        rx_count <= rx_count + 1;
        if (rx_count % 128 == 0) rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_ALWAYS:  i_m_axis_tready <= 1'b1;
            RX_RANDOM:  i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: i_m_axis_tready <= (rx_count % 5 != 3);
            default:    i_m_axis_tready <= (rx_count % 32 < 24);
        endcase
    end

    // transaction monitor on both streams
    always @(posedge i_clk) begin
        t_gemm_op op;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                op.act   = t_action'(i_s_axis_tuser);
                op.idx   = i_s_axis_tdata[3:0];
                op.a     = i_s_axis_tdata[35:4];
                op.b     = i_s_axis_tdata[67:36];
                op.sum   = i_s_axis_tdata[99:68];
                op.prior = i_s_axis_tdata[131:100];
                chk.absorb_op(op);
            end
            if (o_m_axis_tvalid && i_m_axis_tready)
                chk.check_elem(o_m_axis_tdata[31:0], o_m_axis_tdata[35:32]);
        end
    end

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return VAL_W'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_gemm_op make_op(t_action act, logic [IDX_W-1:0] idx,
                                         logic [VAL_W-1:0] sum, logic [VAL_W-1:0] prior,
                                         logic [31:0] a, logic [31:0] b);
        t_gemm_op op;
        op.act   = act;
        op.idx   = idx;
        op.a     = a;
        op.b     = b;
        op.sum   = sum;
        op.prior = prior;
        return op;
    endfunction

    function automatic t_gemm_op rand_op(t_action act, logic [IDX_W-1:0] idx);
        t_gemm_op op;
        op.act   = act;
        op.idx   = idx;
        op.sum   = pick_word();
        op.prior = pick_word();
        for (int i = 0; i < TILE_MAX; i++) begin
            op.a[i] = pick_byte();
            op.b[i] = pick_byte();
        end
        return op;
    endfunction

    // bursts of transactions with random gaps
    task automatic pace();
        int gap;
        if (!gaps_on) return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap        = $urandom_range(1, 7);
        burst_left = $urandom_range(0, 24);
        i_s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic issue_op(t_gemm_op op);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op.act;
        i_s_axis_tdata  <= {4'b0, op.prior, op.sum, op.b, op.a, op.idx};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (!((op.act == ACT_ROW_SUM && op.idx >= ROWS) ||
              (op.act == ACT_COL_SUM && op.idx >= COLS)))
            ops_issued++;
        pace();
    endtask

    // wait for every result, then let the k-slice chain drain
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (chk.waiting() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_zero_mode(bit v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        chk.set_zero_mode(v);
    endtask

    // setup, up to eight k-slices, then finishes for most elements of the tile
    task automatic run_tile_job();
        int nk;
        int base;
        for (int r = 0; r < TILE_MAX; r++)
            if ($urandom_range(0, 5) != 0) issue_op(rand_op(ACT_ROW_SUM, IDX_W'(r)));
        for (int c = 0; c < TILE_MAX; c++)
            if ($urandom_range(0, 5) != 0) issue_op(rand_op(ACT_COL_SUM, IDX_W'(c)));
        nk = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        repeat (nk) issue_op(rand_op(ACT_KSLICE, IDX_W'($urandom)));
        base = $urandom_range(0, ELEMS - 1);
        for (int e = 0; e < ELEMS; e++) begin
            if ($urandom_range(0, 15) != 0) issue_op(rand_op(ACT_FINISH, IDX_W'(base + e)));
        end
    endtask

    task automatic run_noise();
        repeat ($urandom_range(1, 6))
            issue_op(rand_op(t_action'($urandom_range(0, 3)), IDX_W'($urandom)));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_zero_mode(1'b1);

        // extremes of the sums and bytes, out-of-tile setup, repeated finish
        issue_op(make_op(ACT_ROW_SUM, 4'd0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0));
        issue_op(make_op(ACT_ROW_SUM, 4'd3, 32'h8000_0000, 32'h0, 32'h0, 32'h0));
        issue_op(make_op(ACT_ROW_SUM, 4'd1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
        issue_op(make_op(ACT_ROW_SUM, 4'd2, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0));
        issue_op(make_op(ACT_COL_SUM, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0));
        issue_op(make_op(ACT_COL_SUM, 4'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0));
        issue_op(make_op(ACT_COL_SUM, 4'd1, 32'h0, 32'h8000_0000, 32'h0, 32'h0));
        issue_op(make_op(ACT_COL_SUM, 4'd2, 32'h7FFF_FFFF, 32'h1, 32'h0, 32'h0));
        issue_op(make_op(ACT_ROW_SUM, 4'd15, 32'h1234_5678, 32'h0, 32'h0, 32'h0));
        issue_op(make_op(ACT_COL_SUM, 4'd4, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0, 32'h0));
        issue_op(make_op(ACT_KSLICE, 4'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        issue_op(make_op(ACT_KSLICE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0));
        issue_op(make_op(ACT_KSLICE, 4'd7, 32'h0, 32'h0, 32'h80FF_0100, 32'h0180_00FF));
        issue_op(make_op(ACT_FINISH, 4'd0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0));
        issue_op(make_op(ACT_FINISH, 4'd3, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0));
        issue_op(make_op(ACT_FINISH, 4'd5, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0));
        issue_op(make_op(ACT_FINISH, 4'd10, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0));
        issue_op(make_op(ACT_FINISH, 4'd12, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0));
        issue_op(make_op(ACT_FINISH, 4'd15, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0));
        issue_op(make_op(ACT_FINISH, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0));
        settle();
        write_zero_mode(1'b0);
        issue_op(make_op(ACT_FINISH, 4'd15, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0));
        issue_op(make_op(ACT_FINISH, 4'd6, 32'h0, 32'h8000_0000, 32'h0, 32'h0));
        issue_op(make_op(ACT_KSLICE, 4'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        issue_op(make_op(ACT_FINISH, 4'd5, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0));
        settle();

        for (int p = 0; p < PHASES; p++) begin
            write_zero_mode(p % 2 == 0);
            gaps_on = (p != 2);
            ops_issued = 0;
            while (ops_issued < PHASE_OPS) begin
                if ($urandom_range(0, 4) != 0) run_tile_job();
                else run_noise();
            end
            settle();
        end

        if (chk.errors == 0 && chk.waiting() == 0)
            $display("** int8_gemm_tile_zero_point: PASSED **");
        else
            $display("** int8_gemm_tile_zero_point: FAILED **");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/i8gemm_pkg.sv
hw/rtl/i8gemm_cell.sv
hw/rtl/i8gemm_finish.sv
hw/rtl/int8_gemm_tile_zero_point.sv
tb/tb_top.sv
